[src/tme_pkg.sv]
// shared types and constants for the tolerance match and eliminate block
package tme_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned CFG_ADDR_W = 2;

    // 10.0 in Q16.16
    localparam logic [VALUE_W-1:0] PASS_START = 32'd655360;
    // 1.0 in Q16.16
    localparam logic [VALUE_W-1:0] TOL_RESET = 32'd65536;
    localparam logic [VALUE_W-1:0] BEST_RESET = '1;

    localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_COUNT = 2'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

[src/tolerance_match_eliminate.sv]
// value table with tolerance matching, first-hit elimination and closest tracking
// a load is written in its accept cycle and gives no result
// a match compares up to n = min(entry_count, TABLE_DEPTH) entries, then registers its result,
// one entry compare per cycle through the single table read port, fewer on an early hit
// one item at a time: input ready only while the sequencer is idle
// synchronous active-low reset: tolerance 1.0, entry count 0, pass minimum 10.0,
// best all ones; table contents are undefined until loaded
module tolerance_match_eliminate #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tme_pkg::CFG_ADDR_W-1:0]      i_cfg_index,
    input  logic [tme_pkg::VALUE_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_cmd,
    input  logic [tme_pkg::INDEX_W-1:0]         i_entry_index,
    input  logic [tme_pkg::VALUE_W-1:0]         i_item_value,
    input  logic                                i_pass_end,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic [tme_pkg::INDEX_W-1:0]         o_hit_index,
    output logic [tme_pkg::VALUE_W-1:0]         o_pass_closest,
    output logic [tme_pkg::VALUE_W-1:0]         o_best_closest
);
    import tme_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned LW = (CW > COUNT_W) ? CW : COUNT_W;

    logic [VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    t_state             r_state, n_state;
    logic [VALUE_W-1:0] r_tol;
    logic [COUNT_W-1:0] r_entry_count;
    logic [VALUE_W-1:0] r_pass_min, n_pass_min;
    logic [VALUE_W-1:0] r_best, n_best;
    logic [VALUE_W-1:0] r_val;
    logic               r_last;
    logic [CW-1:0]      r_limit;
    logic [AW-1:0]      r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]      r_rd_idx, n_rd_idx;
    logic               r_hit, n_hit;
    logic [AW-1:0]      r_hit_idx, n_hit_idx;

    logic               r_out_valid, n_out_valid;
    logic               r_out_hit;
    logic [INDEX_W-1:0] r_out_hit_idx;
    logic [VALUE_W-1:0] r_out_pass;

    logic               in_xfer;
    logic               out_free;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W:0]   sub;
    logic [VALUE_W-1:0] diff;
    logic               within_tol;
    logic               scan_last;
    logic [LW-1:0]      limit_full;
    logic               load_in_range;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // shared compare unit: absolute difference of item and current entry
    assign sub = {1'b0, r_val} - {1'b0, r_rdata};
    assign diff = sub[VALUE_W] ? (~sub[VALUE_W-1:0] + 1'b1) : sub[VALUE_W-1:0];
    assign within_tol = (diff < r_tol);
    assign scan_last = ((CW'(r_cmp_idx) + CW'(1)) == r_limit);

    assign limit_full = (LW'(r_entry_count) > LW'(TABLE_DEPTH)) ?
                        LW'(TABLE_DEPTH) : LW'(r_entry_count);
    assign load_in_range = (32'(i_entry_index) < 32'(TABLE_DEPTH));

    always_comb begin
        mem_we = 1'b0;
        mem_waddr = AW'(i_entry_index);
        mem_wdata = i_item_value;
        if (in_xfer && i_cmd == CMD_LOAD && load_in_range) begin
            mem_we = 1'b1;
        end else if (r_state == ST_SCAN && within_tol) begin
            // eliminate the matched entry
            mem_we = 1'b1;
            mem_waddr = r_cmp_idx;
            mem_wdata = '0;
        end
    end

    assign mem_raddr = (r_state == ST_SCAN) ? r_rd_idx : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state = r_state;
        n_pass_min = r_pass_min;
        n_best = r_best;
        n_cmp_idx = r_cmp_idx;
        n_rd_idx = r_rd_idx;
        n_hit = r_hit;
        n_hit_idx = r_hit_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_cmd == CMD_MATCH) begin
                    n_cmp_idx = '0;
                    n_rd_idx = AW'(1);
                    n_hit = 1'b0;
                    n_hit_idx = '0;
                    n_state = (limit_full == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (within_tol) begin
                    n_hit = 1'b1;
                    n_hit_idx = r_cmp_idx;
                    n_state = ST_DONE;
                end else begin
                    if (diff < r_pass_min) begin
                        n_pass_min = diff;
                    end
                    if (scan_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_cmp_idx = r_cmp_idx + 1'b1;
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_last) begin
                        if (r_pass_min < r_best) begin
                            n_best = r_pass_min;
                        end
                        n_pass_min = PASS_START;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tol <= TOL_RESET;
            r_entry_count <= '0;
            r_pass_min <= PASS_START;
            r_best <= BEST_RESET;
            r_out_valid <= 1'b0;
            r_limit <= '0;
            r_cmp_idx <= '0;
            r_rd_idx <= '0;
            r_hit <= 1'b0;
            r_hit_idx <= '0;
        end else begin
            r_state <= n_state;
            r_pass_min <= n_pass_min;
            r_best <= n_best;
            r_out_valid <= n_out_valid;
            r_cmp_idx <= n_cmp_idx;
            r_rd_idx <= n_rd_idx;
            r_hit <= n_hit;
            r_hit_idx <= n_hit_idx;
            if (in_xfer && i_cmd == CMD_MATCH) begin
                r_limit <= CW'(limit_full);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TOLERANCE:   r_tol <= i_cfg_data;
                    REG_ENTRY_COUNT: r_entry_count <= i_cfg_data[COUNT_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // item payload and output payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_cmd == CMD_MATCH) begin
            r_val <= i_item_value;
            r_last <= i_pass_end;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_hit <= r_hit;
            r_out_hit_idx <= INDEX_W'(r_hit_idx);
            r_out_pass <= r_pass_min;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit = r_out_hit;
    assign o_hit_index = r_out_hit_idx;
    assign o_pass_closest = r_out_pass;
    assign o_best_closest = r_best;

    a_pass_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pass_closest <= PASS_START))
        else $error("pass closest above start value");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_hit_index == '0))
        else $error("hit index nonzero without a hit");

    a_scan_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CW'(r_cmp_idx) < r_limit))
        else $error("scan index beyond entry limit");

    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_best <= $past(r_best)))
        else $error("best minimum increased");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside completion");

endmodule
